>>> hw/rtl/ssfa_pkg.sv
// shared constants, types and register codes of the sonar scan spike filter
// used by the top level and its port checker; no dependencies
package ssfa_pkg;

  localparam int unsigned SENSOR_COUNT_DEF  = 4;
  localparam int unsigned HISTORY_DEPTH_DEF = 8;
  localparam int unsigned ADC_BITS_DEF      = 10;

  localparam int unsigned MM_W      = 15;
  localparam int unsigned ADC_IN_W  = 10;
  localparam int unsigned CH_OUT_W  = 2;
  localparam int unsigned SCALE_W   = 5;
  localparam int unsigned WAIT_W    = 4;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned IN_DATA_W = 16;
  localparam int unsigned TDATA_W   = 56;
  localparam int unsigned TUSER_W   = 1;

  localparam logic [MM_W-1:0]    MM_MAX     = 15'd32767;
  localparam logic [MM_W-1:0]    RAW_RESET  = 15'd32000;
  localparam logic [WAIT_W-1:0]  RESET_WAIT = 4'd10;

  localparam logic [SCALE_W-1:0] SCALE_RST  = 5'd12;
  localparam logic [WAIT_W-1:0]  WAIT_RST   = 4'd2;
  localparam logic [MM_W-1:0]    MARGIN_RST = 15'd100;
  localparam logic [MM_W-1:0]    MAXR_RST   = 15'd3600;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXR   = 8'd3;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HIST = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_PUSH = 5'b10000
  } state_e;

endpackage

>>> hw/rtl/ssfa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ssfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sonar_scan_spike_filter_average_top.sv
// scanning range-sensor sequencer: spike filter and per-channel moving average
// depends on ssfa_pkg and ssfa_ram
//
// One input transaction is one tick carrying the converter sample of the
// channel announced in next_read_channel; every tick gives exactly one result
// transaction. Idle ticks (10 after reset, wait_ticks after each reading)
// go from ST_IDLE to ST_PUSH. A reading tick issues the channel record read
// in ST_IDLE, reads the history memory in ST_HIST, writes both back in ST_UPD,
// then in ST_DIV a restoring divider produces the 15-bit window mean one
// quotient bit per cycle, starting from the upper sum bits, which always lie
// below the window count. The next tick is taken once the result sits in the
// output register, even if that result has not been taken yet. A per-channel
// valid bit beside the record memory spares a clearing pass after reset.
// Configuration writes are taken every cycle and belong to idle periods.
module sonar_scan_spike_filter_average_top #(
  parameter int unsigned SENSOR_COUNT  = ssfa_pkg::SENSOR_COUNT_DEF,
  parameter int unsigned HISTORY_DEPTH = ssfa_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned ADC_BITS      = ssfa_pkg::ADC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // adc_sample [9:0], zeros above
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [ssfa_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // read_channel [1:0], trigger_channel [3:2], raw_range_mm [18:4],
  // accepted [19], accepted_range_mm [34:20], average_mm [49:35],
  // next_read_channel [51:50], zeros above
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [ssfa_pkg::TDATA_W-1:0]       m_axis_tdata_o,
  // sample_taken [0]
  output logic [ssfa_pkg::TUSER_W-1:0]       m_axis_tuser_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ssfa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ssfa_pkg::MM_W-1:0]          cfg_data_i
);

  import ssfa_pkg::*;

  localparam int unsigned CHW    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int unsigned STW    = (SENSOR_COUNT > 1) ? $clog2(2 * SENSOR_COUNT) : 1;
  localparam int unsigned PW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW     = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W  = MM_W + CW;
  localparam int unsigned DCW    = $clog2(SUM_W + 1);
  localparam int unsigned HDEPTH = SENSOR_COUNT * HISTORY_DEPTH;
  localparam int unsigned HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int unsigned SMP_W  = (ADC_BITS < ADC_IN_W) ? ADC_BITS : ADC_IN_W;
  localparam int unsigned PRW    = SMP_W + SCALE_W;

  // channel record layout, lowest field first
  localparam int unsigned OFF_ACCV = MM_W;
  localparam int unsigned OFF_VLD  = 2 * MM_W;
  localparam int unsigned OFF_PTR  = OFF_VLD + 1;
  localparam int unsigned OFF_CNT  = OFF_PTR + PW;
  localparam int unsigned OFF_SUM  = OFF_CNT + CW;
  localparam int unsigned REC_W    = OFF_SUM + SUM_W;

  localparam logic [REC_W-1:0]  REC_RESET = {{(REC_W - MM_W){1'b0}}, RAW_RESET};
  localparam logic [HAW-1:0]    HD_A      = HAW'(HISTORY_DEPTH);
  localparam logic [CW-1:0]     HD_C      = CW'(HISTORY_DEPTH);
  localparam logic [PW-1:0]     PTR_LAST  = PW'(HISTORY_DEPTH - 1);
  localparam logic [STW-1:0]    SC_S      = STW'(SENSOR_COUNT);
  localparam logic [DCW-1:0]    DIV_STEPS = DCW'(MM_W);

  function automatic logic [MM_W-1:0] abs_diff(input logic [MM_W-1:0] a,
                                               input logic [MM_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CHW-1:0] chan_of(input logic [STW-1:0] step);
    logic [CHW-1:0] ch;
    ch = '0;
    if (SENSOR_COUNT > 1 && step[0]) begin
      ch = CHW'((step >> 1) + STW'(1));
    end
    return ch;
  endfunction

  // configuration
  logic [SCALE_W-1:0] scale_q, scale_d;
  logic [WAIT_W-1:0]  wait_tk_q, wait_tk_d;
  logic [MM_W-1:0]    margin_q, margin_d;
  logic [MM_W-1:0]    maxr_q, maxr_d;

  // control
  state_e             state_q, state_d;
  logic [WAIT_W-1:0]  wait_q, wait_d;
  logic [STW-1:0]     step_q, step_d;
  logic [SENSOR_COUNT-1:0] vld_q, vld_d;
  logic [DCW-1:0]     dcnt_q, dcnt_d;
  logic               m_valid_q, m_valid_d;

  // work payload
  logic               taken_q, taken_d;
  logic [CHW-1:0]     rd_q, rd_d;
  logic [CHW-1:0]     trig_q, trig_d;
  logic [MM_W-1:0]    raw_q, raw_d;
  logic               acc_q, acc_d;
  logic [MM_W-1:0]    accout_q, accout_d;
  logic [REC_W-1:0]   rec_q, rec_d;
  logic [HAW-1:0]     haddr_q, haddr_d;
  logic [MM_W-1:0]    dvd_q, dvd_d;
  logic [CW-1:0]      dsr_q, dsr_d;
  logic [CW-1:0]      rem_q, rem_d;
  logic [TDATA_W-1:0] m_data_q, m_data_d;
  logic               m_user_q, m_user_d;

  // memory ports
  logic               chan_we;
  logic [CHW-1:0]     chan_raddr;
  logic [REC_W-1:0]   chan_rdata, chan_wdata;
  logic               hist_we;
  logic [HAW-1:0]     hist_raddr;
  logic [MM_W-1:0]    hist_rdata;

  // tick scheduling
  logic [CHW-1:0]     rd_now, trig_now;
  logic [STW-1:0]     step_inc, step_nxt;
  logic [PRW-1:0]     prod;
  logic [MM_W:0]      prod_x;
  logic [MM_W-1:0]    raw_now;

  // record fields
  logic [REC_W-1:0]   rec_cur;
  logic [PW-1:0]      cur_ptr;
  logic [MM_W-1:0]    rq_last, rq_accv;
  logic               rq_vld;
  logic [PW-1:0]      rq_ptr, ptr_new;
  logic [CW-1:0]      rq_cnt, cnt_new;
  logic [SUM_W-1:0]   rq_sum, sum_base, sum_new;
  logic               near_raw, near_acc, acc_now, full;
  logic [MM_W-1:0]    accv_new;
  logic               vld_new;

  // divider step
  logic [CW:0]        rem_sh;
  logic               q_bit;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // schedule: even step reads sensor 0, odd step reads sensor (step/2)+1
  always_comb begin
    rd_now   = '0;
    trig_now = '0;
    step_inc = step_q + STW'(1);
    step_nxt = '0;
    if (SENSOR_COUNT > 1) begin
      if (!step_q[0]) begin
        trig_now = CHW'((step_q >> 1) + STW'(1));
      end else begin
        rd_now = CHW'((step_q >> 1) + STW'(1));
      end
      step_nxt = (((step_inc >> 1) + STW'(1)) >= SC_S) ? '0 : step_inc;
    end
  end

  assign prod    = PRW'(s_axis_tdata_i[SMP_W-1:0]) * PRW'(scale_q);
  assign prod_x  = (MM_W + 1)'(prod);
  assign raw_now = (prod_x > {1'b0, MM_MAX}) ? MM_MAX : prod_x[MM_W-1:0];

  assign rec_cur    = vld_q[rd_q] ? chan_rdata : REC_RESET;
  assign cur_ptr    = rec_cur[OFF_PTR +: PW];
  assign hist_raddr = HAW'(HAW'(rd_q) * HD_A) + HAW'(cur_ptr);
  assign chan_raddr = rd_now;

  assign rq_last = rec_q[MM_W-1:0];
  assign rq_accv = rec_q[OFF_ACCV +: MM_W];
  assign rq_vld  = rec_q[OFF_VLD];
  assign rq_ptr  = rec_q[OFF_PTR +: PW];
  assign rq_cnt  = rec_q[OFF_CNT +: CW];
  assign rq_sum  = rec_q[OFF_SUM +: SUM_W];

  assign near_raw = abs_diff(raw_q, rq_last) < margin_q;
  assign near_acc = rq_vld && (abs_diff(raw_q, rq_accv) < margin_q);
  assign acc_now  = (near_raw || near_acc) && (raw_q < maxr_q);
  assign accv_new = acc_now ? raw_q : rq_accv;
  assign vld_new  = acc_now || rq_vld;

  // oldest entry leaves the window only once it is full
  assign full     = (rq_cnt >= HD_C);
  assign sum_base = full ? (rq_sum - SUM_W'(hist_rdata)) : rq_sum;
  assign sum_new  = sum_base + SUM_W'(raw_q);
  assign cnt_new  = full ? rq_cnt : (rq_cnt + CW'(1));
  assign ptr_new  = (rq_ptr == PTR_LAST) ? '0 : (rq_ptr + PW'(1));

  assign chan_wdata = {sum_new, cnt_new, ptr_new, vld_new, accv_new, raw_q};
  assign chan_we    = (state_q == ST_UPD);
  assign hist_we    = (state_q == ST_UPD);

  assign rem_sh = {rem_q, dvd_q[MM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dsr_q});

  always_comb begin
    scale_d   = scale_q;
    wait_tk_d = wait_tk_q;
    margin_d  = margin_q;
    maxr_d    = maxr_q;
    state_d   = state_q;
    wait_d    = wait_q;
    step_d    = step_q;
    vld_d     = vld_q;
    dcnt_d    = dcnt_q;
    m_valid_d = m_valid_q;
    taken_d   = taken_q;
    rd_d      = rd_q;
    trig_d    = trig_q;
    raw_d     = raw_q;
    acc_d     = acc_q;
    accout_d  = accout_q;
    rec_d     = rec_q;
    haddr_d   = haddr_q;
    dvd_d     = dvd_q;
    dsr_d     = dsr_q;
    rem_d     = rem_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SCALE:  scale_d   = cfg_data_i[SCALE_W-1:0];
        CFG_WAIT:   wait_tk_d = cfg_data_i[WAIT_W-1:0];
        CFG_MARGIN: margin_d  = cfg_data_i;
        CFG_MAXR:   maxr_d    = cfg_data_i;
        default: ;
      endcase
    end

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (wait_q != '0) begin
            wait_d   = wait_q - WAIT_W'(1);
            taken_d  = 1'b0;
            rd_d     = '0;
            trig_d   = '0;
            raw_d    = '0;
            acc_d    = 1'b0;
            accout_d = '0;
            dvd_d    = '0;
            state_d  = ST_PUSH;
          end else begin
            // record read of rd_now is issued this cycle
            wait_d  = wait_tk_q;
            taken_d = 1'b1;
            rd_d    = rd_now;
            trig_d  = trig_now;
            raw_d   = raw_now;
            step_d  = step_nxt;
            state_d = ST_HIST;
          end
        end
      end
      ST_HIST: begin
        rec_d   = rec_cur;
        haddr_d = hist_raddr;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        vld_d[rd_q] = 1'b1;
        acc_d    = acc_now;
        accout_d = vld_new ? accv_new : '0;
        // upper sum bits are below the count, so the quotient fits MM_W bits
        dvd_d    = sum_new[MM_W-1:0];
        dsr_d    = cnt_new;
        rem_d    = sum_new[SUM_W-1:MM_W];
        dcnt_d   = DIV_STEPS;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = q_bit ? CW'(rem_sh - {1'b0, dsr_q}) : CW'(rem_sh);
        dvd_d  = {dvd_q[MM_W-2:0], q_bit};
        dcnt_d = dcnt_q - DCW'(1);
        if (dcnt_q == DCW'(1)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_user_d  = taken_q;
          m_data_d  = {{(TDATA_W - 52){1'b0}},
                       CH_OUT_W'(chan_of(step_q)),
                       dvd_q[MM_W-1:0],
                       accout_q,
                       acc_q,
                       raw_q,
                       CH_OUT_W'(trig_q),
                       CH_OUT_W'(rd_q)};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= SCALE_RST;
      wait_tk_q <= WAIT_RST;
      margin_q  <= MARGIN_RST;
      maxr_q    <= MAXR_RST;
      state_q   <= ST_IDLE;
      wait_q    <= RESET_WAIT;
      step_q    <= '0;
      vld_q     <= '0;
      dcnt_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      scale_q   <= scale_d;
      wait_tk_q <= wait_tk_d;
      margin_q  <= margin_d;
      maxr_q    <= maxr_d;
      state_q   <= state_d;
      wait_q    <= wait_d;
      step_q    <= step_d;
      vld_q     <= vld_d;
      dcnt_q    <= dcnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    taken_q  <= taken_d;
    rd_q     <= rd_d;
    trig_q   <= trig_d;
    raw_q    <= raw_d;
    acc_q    <= acc_d;
    accout_q <= accout_d;
    rec_q    <= rec_d;
    haddr_q  <= haddr_d;
    dvd_q    <= dvd_d;
    dsr_q    <= dsr_d;
    rem_q    <= rem_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  ssfa_ram #(
    .WIDTH (REC_W),
    .DEPTH (SENSOR_COUNT)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (chan_we),
    .waddr_i (rd_q),
    .wdata_i (chan_wdata),
    .raddr_i (chan_raddr),
    .rdata_o (chan_rdata)
  );

  ssfa_ram #(
    .WIDTH (MM_W),
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (haddr_q),
    .wdata_i (raw_q),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

endmodule

>>> hw/rtl/ssfa_checker.sv
// port-level checks of the sonar scan spike filter, bound to the top level
// depends on ssfa_pkg
module ssfa_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid_i,
  input logic                               s_axis_tready_o,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [ssfa_pkg::TDATA_W-1:0]       m_axis_tdata_o,
  input logic [ssfa_pkg::TUSER_W-1:0]       m_axis_tuser_o
);

  import ssfa_pkg::*;

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // one tick at a time
  a_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("tick accepted while previous one in flight");

  // idle tick carries only the next channel
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[49:0] == '0)
    else $error("idle tick with nonzero reading fields");

  // an accepted reading becomes the accepted range
  a_acc_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[19] |->
      m_axis_tuser_o[0] && (m_axis_tdata_o[34:20] == m_axis_tdata_o[18:4]))
    else $error("accepted range differs from accepted reading");

endmodule

bind sonar_scan_spike_filter_average_top ssfa_checker u_ssfa_checker (.*);

>>> sim/sonar_scan_spike_filter_average_top_test.sv
// self-checking testbench for sonar_scan_spike_filter_average_top
// drives ticks from a queue, predicts every result in-line and checks each field
// depends on ssfa_pkg and the top level rtl only
`timescale 1ns / 100ps

module sonar_scan_spike_filter_average_top_test;

  localparam int unsigned N_CH        = ssfa_pkg::SENSOR_COUNT_DEF;
  localparam int unsigned H_DEPTH     = ssfa_pkg::HISTORY_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE      = 40;

  typedef struct packed {
    logic        taken;
    logic [1:0]  rd_ch;
    logic [1:0]  trig_ch;
    logic [14:0] raw;
    logic        acc;
    logic [14:0] acc_mm;
    logic [14:0] avg_mm;
    logic [1:0]  next_ch;
  } tick_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [ssfa_pkg::IN_DATA_W-1:0]      s_tdata = '0;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [ssfa_pkg::TDATA_W-1:0]        m_tdata;
  logic [ssfa_pkg::TUSER_W-1:0]        m_tuser;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [ssfa_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [ssfa_pkg::MM_W-1:0]           cfg_data = '0;

  sonar_scan_spike_filter_average_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of the registers
  int unsigned scale_cfg, wait_cfg, margin_cfg, maxr_cfg;

  // predictor copy of the sequencer and per-channel filter state
  int unsigned wait_left, sched_step;
  int unsigned last_raw_mm [N_CH];
  int unsigned acc_mm [N_CH];
  bit          acc_vld [N_CH];
  int unsigned hist_mm [N_CH][H_DEPTH];
  int unsigned hist_cnt [N_CH];
  int unsigned hist_ptr [N_CH];
  int unsigned hist_sum [N_CH];

  logic [9:0]   adc_sample_q [$];
  tick_result_t tick_result_q [$];

  int unsigned ticks_sent = 0;
  int unsigned ticks_taken = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 55;
  int          level = 250;

  function automatic int unsigned mm_gap(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic tick_result_t predict_tick(input logic [9:0] adc);
    tick_result_t r;
    int unsigned  prod, p, rd;
    bit           near_raw, near_acc;
    r = '0;
    if (wait_left != 0) begin
      wait_left--;
    end else begin
      r.taken = 1'b1;
      if (sched_step % 2 == 0) begin
        rd = 0;
        r.trig_ch = 2'(sched_step / 2 + 1);
      end else begin
        rd = sched_step / 2 + 1;
        r.trig_ch = 2'd0;
      end
      r.rd_ch = 2'(rd);
      sched_step++;
      if (sched_step / 2 + 1 >= N_CH) sched_step = 0;

      prod = adc * scale_cfg;
      r.raw = (prod > 32767) ? 15'h7fff : 15'(prod);

      // no accepted value yet means only the last raw reading can vouch for it
      near_raw = mm_gap(r.raw, last_raw_mm[rd]) < margin_cfg;
      near_acc = acc_vld[rd] && (mm_gap(r.raw, acc_mm[rd]) < margin_cfg);
      if ((near_raw || near_acc) && r.raw < maxr_cfg) begin
        acc_mm[rd] = r.raw;
        acc_vld[rd] = 1'b1;
        r.acc = 1'b1;
      end
      last_raw_mm[rd] = r.raw;
      wait_left = wait_cfg;

      p = hist_ptr[rd];
      if (hist_cnt[rd] >= H_DEPTH) hist_sum[rd] -= hist_mm[rd][p];
      else hist_cnt[rd]++;
      hist_mm[rd][p] = r.raw;
      hist_sum[rd] += r.raw;
      hist_ptr[rd] = (p + 1) % H_DEPTH;
      r.avg_mm = 15'(hist_sum[rd] / hist_cnt[rd]);
      r.acc_mm = acc_vld[rd] ? 15'(acc_mm[rd]) : 15'd0;
    end
    r.next_ch = (sched_step % 2 == 1) ? 2'(sched_step / 2 + 1) : 2'd0;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // tick driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (adc_sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, adc_sample_q.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result checker and tick predictor
  always @(posedge clk_i) begin : mon
    tick_result_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (tick_result_q.size() == 0) begin
          $error("result transaction with no tick pending");
          errors++;
        end else begin
          want = tick_result_q.pop_front();
          check_field("sample_taken", want.taken, m_tuser[0]);
          check_field("read_channel", want.rd_ch, m_tdata[1:0]);
          check_field("trigger_channel", want.trig_ch, m_tdata[3:2]);
          check_field("raw_range_mm", want.raw, m_tdata[18:4]);
          check_field("accepted", want.acc, m_tdata[19]);
          check_field("accepted_range_mm", want.acc_mm, m_tdata[34:20]);
          check_field("average_mm", want.avg_mm, m_tdata[49:35]);
          check_field("next_read_channel", want.next_ch, m_tdata[51:50]);
        end
      end
      if (s_tvalid && s_tready) begin
        tick_result_q.push_back(predict_tick(s_tdata[9:0]));
        ticks_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [ssfa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ssfa_pkg::MM_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ssfa_pkg::CFG_SCALE:  scale_cfg = val[4:0];
      ssfa_pkg::CFG_WAIT:   wait_cfg = val[3:0];
      ssfa_pkg::CFG_MARGIN: margin_cfg = val;
      ssfa_pkg::CFG_MAXR:   maxr_cfg = val;
      default: ;
    endcase
  endtask

  // unused upper data bits carry noise, and an unmapped index is poked as well
  task automatic configure(input int unsigned sc, input int unsigned wt,
                           input int unsigned mg, input int unsigned mx);
    write_reg(ssfa_pkg::CFG_SCALE, {10'($urandom), 5'(sc)});
    write_reg(ssfa_pkg::CFG_WAIT, {11'($urandom), 4'(wt)});
    write_reg(ssfa_pkg::CFG_MARGIN, 15'(mg));
    write_reg(ssfa_pkg::CFG_MAXR, 15'(mx));
    write_reg(($urandom_range(0, 1) != 0) ? 8'hff : 8'(4 + $urandom_range(0, 3)),
              15'($urandom));
  endtask

  task automatic push_tick(input logic [9:0] adc);
    adc_sample_q.push_back(adc);
    ticks_sent++;
  endtask

  // slowly wandering level with small jitter, occasional jumps and spikes
  task automatic queue_ticks(input int unsigned n_ticks);
    int unsigned lim;
    int          s;
    lim = (scale_cfg == 0) ? 1023 : maxr_cfg / scale_cfg;
    if (lim > 1023) lim = 1023;
    for (int unsigned i = 0; i < n_ticks; i++) begin
      if ($urandom_range(0, 99) < 6) level = $urandom_range(0, lim);
      else if ($urandom_range(0, 99) < 3) level = lim;
      if ($urandom_range(0, 99) < 10) s = $urandom_range(0, 1023);
      else s = level + int'($urandom_range(0, 4)) - 2;
      if (s < 0) s = 0;
      if (s > 1023) s = 1023;
      push_tick(10'(s));
    end
  endtask

  task automatic drain();
    while (ticks_taken != ticks_sent || tick_result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin : stim
    logic [9:0] directed [25];
    int unsigned wt;
    scale_cfg  = ssfa_pkg::SCALE_RST;
    wait_cfg   = ssfa_pkg::WAIT_RST;
    margin_cfg = ssfa_pkg::MARGIN_RST;
    maxr_cfg   = ssfa_pkg::MAXR_RST;
    wait_left  = ssfa_pkg::RESET_WAIT;
    sched_step = 0;
    for (int c = 0; c < N_CH; c++) begin
      last_raw_mm[c] = ssfa_pkg::RAW_RESET;
      acc_mm[c]      = 0;
      acc_vld[c]     = 1'b0;
      hist_cnt[c]    = 0;
      hist_ptr[c]    = 0;
      hist_sum[c]    = 0;
    end

    // ten start-up idle ticks, then back-to-back readings on the default filter:
    // first readings, acceptance through the accepted value, range exactly at
    // the maximum, spikes and converter extremes
    directed = '{10'd0, 10'd1023, 10'h2aa, 10'h155, 10'd0, 10'd1023, 10'd0, 10'd1023,
                 10'h155, 10'h2aa,
                 10'd250, 10'd250, 10'd251, 10'd1023, 10'd258, 10'd0, 10'd300, 10'd299,
                 10'd266, 10'd1023, 10'd266, 10'd0, 10'd299, 10'd299, 10'd300};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(ssfa_pkg::CFG_WAIT, 15'd0);
    foreach (directed[i]) push_tick(directed[i]);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 30;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: configure(12, 2, 100, 3600);
        1: configure(0, 15, 0, 32767);
        2: configure(31, 0, 32767, 32767);
        3: configure(1, 1, 5, 0);
        default: begin
          wt = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
          scale_cfg = $urandom_range(1, 31);
          configure(scale_cfg, wt, $urandom_range(scale_cfg, scale_cfg * 40),
                    $urandom_range(500, 32767));
        end
      endcase
      queue_ticks(16 * (wait_cfg + 1) + 40);
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ssfa_pkg.sv
hw/rtl/ssfa_ram.sv
hw/rtl/sonar_scan_spike_filter_average_top.sv
hw/rtl/ssfa_checker.sv
sim/sonar_scan_spike_filter_average_top_test.sv
